FILE: design/uartrb_pkg.sv
package uartrb_pkg;

  localparam int DEF_RX_DEPTH = 256;
  localparam int DEF_TX_DEPTH = 256;

  localparam int BYTE_W     = 8;
  localparam int OP_W       = 3;
  localparam int FILL_W     = 9;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  localparam logic [BYTE_W-1:0] CH_XOFF = 8'h13;
  localparam logic [BYTE_W-1:0] CH_XON  = 8'h11;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_RECV  = 3'd2,
    OP_TXRDY = 3'd3,
    OP_DRAIN = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_WR_REFUSED = 3'd1,
    STS_RD_REFUSED = 3'd2,
    STS_RX_DROP    = 3'd3,
    STS_FLOW       = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECHO       = 3'd0,
    CFG_CRLF       = 3'd1,
    CFG_HONOR_XOFF = 3'd2,
    CFG_SEND_XOFF  = 3'd3,
    CFG_ANY_RESUME = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // push2: a second byte (wdata2) follows wdata into the ring
  typedef struct packed {
    logic              push;
    logic              push2;
    logic              pop;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] wdata2;
  } ring_cmd_t;

endpackage

FILE: design/uartrb_ring.sv
module uartrb_ring
  import uartrb_pkg::*;
#(
  parameter int DEPTH = DEF_RX_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ring_cmd_t         cmd,
  output logic [BYTE_W-1:0] head_q,
  output logic [LW-1:0]     lvl,
  output logic [LW-1:0]     lvl_nxt
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt, tail_inc;
  logic [LW-1:0]     lvl_r;
  logic              wr2_r;
  logic [AW-1:0]     wr2_addr_r;
  logic [BYTE_W-1:0] wr2_data_r;

  always_comb begin
    tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    head_nxt = head_r;
    if (cmd.pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
    end
    tail_nxt = tail_r;
    if (cmd.push) begin
      tail_nxt = tail_inc;
      if (cmd.push2) begin
        tail_nxt = (tail_inc == LAST) ? '0 : tail_inc + 1'b1;
      end
    end
    lvl_nxt = lvl_r + LW'(cmd.push) + LW'(cmd.push & cmd.push2) - LW'(cmd.pop);
  end

  assign lvl = lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      lvl_r  <= '0;
      wr2_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      lvl_r  <= lvl_nxt;
      wr2_r  <= cmd.push & cmd.push2;
    end
  end

  always_ff @(posedge clk) begin
    wr2_addr_r <= tail_inc;
    wr2_data_r <= cmd.wdata2;
  end

  // Second byte of a pair is written in the cycle after the push; the sequencer
  // never issues a command in that cycle, and the head cannot sit on that entry.
  always_ff @(posedge clk) begin
    if (wr2_r) begin
      mem[wr2_addr_r] <= wr2_data_r;
    end else if (cmd.push) begin
      mem[tail_r] <= cmd.wdata;
    end
    head_q <= mem[head_r];
  end

endmodule

FILE: design/uart_ring_buffers_xon_xoff.sv
// A result is registered in the output register when the item commits from the
// execute state; in_tready stays low until then. The ring memories are read at
// accept and updated at commit (read, modify, write back).
// A pending result waits in the output register while the next item is taken.
// Reset (rst_n low, synchronous): pointers, levels and flow state clear, line idle,
// configuration returns to defaults; ring contents are not cleared.
module uart_ring_buffers_xon_xoff
  import uartrb_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic [OP_W-1:0]       in_tuser,   // [2:0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] status, [3] read_valid, [11:4] read_byte, [12] line_tx_valid,
  // [20:13] line_tx_byte, [29:21] rx_fill, [38:30] tx_fill, [39] tx_halted,
  // [40] rx_throttled, [47:41] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic                  cfg_data
);

  localparam int RX_LW = $clog2(RX_DEPTH + 1);
  localparam int TX_LW = $clog2(TX_DEPTH + 1);
  localparam logic [RX_LW-1:0] RX_STOP  = RX_LW'(RX_DEPTH * 3 / 4);
  localparam logic [RX_LW-1:0] RX_START = RX_LW'(RX_DEPTH / 2);

  state_t st_r, st_nxt;
  op_t    op_r;
  logic [BYTE_W-1:0] byte_r;

  logic echo_r, crlf_r, honor_r, sxoff_r, anyres_r;
  logic halt_r, halt_nxt;
  logic thr_r, thr_nxt;
  logic pend_vld_r, pend_vld_nxt;
  logic pend_xon_r, pend_xon_nxt;
  logic idle_r, idle_nxt;

  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_nxt;

  logic accept, commit;

  ring_cmd_t rx_req, tx_req, rx_cmd, tx_cmd;
  logic [BYTE_W-1:0] rx_q, tx_q;
  logic [RX_LW-1:0]  rx_lvl, rx_lvl_nxt;
  logic [TX_LW-1:0]  tx_lvl, tx_lvl_nxt, tx_free;

  status_t           status;
  logic              rd_vld, ln_vld;
  logic [BYTE_W-1:0] rd_byte, ln_byte;

  logic              xon_fire;
  logic [BYTE_W-1:0] hp_byte;
  logic              hp_idle, hp_lf, hp_direct, hp_ok, hp_go;
  logic [1:0]        hp_need;

  uartrb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (rx_cmd),
    .head_q  (rx_q),
    .lvl     (rx_lvl),
    .lvl_nxt (rx_lvl_nxt)
  );

  uartrb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (tx_cmd),
    .head_q  (tx_q),
    .lvl     (tx_lvl),
    .lvl_nxt (tx_lvl_nxt)
  );

  assign accept = in_tvalid && in_tready;
  assign commit = (st_r == ST_EXEC) && (!out_vld_r || out_tready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_EXEC;
      ST_EXEC: if (commit) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (st_r == ST_IDLE);
    cfg_ready  = 1'b1;
    out_tvalid = out_vld_r;
    out_tdata  = out_data_r;
  end

  // Host put, shared by host write and read echo
  always_comb begin
    xon_fire  = thr_r && ((rx_lvl - RX_LW'(1)) <= RX_START);
    hp_byte   = (op_r == OP_READ) ? rx_q : byte_r;
    hp_idle   = (op_r == OP_READ) ? (idle_r && !xon_fire) : idle_r;
    hp_lf     = (hp_byte == CH_LF) && crlf_r;
    hp_direct = (tx_lvl == '0) && !halt_r && hp_idle;
    hp_need   = hp_lf ? (hp_direct ? 2'd1 : 2'd2) : (hp_direct ? 2'd0 : 2'd1);
    tx_free   = TX_LW'(TX_DEPTH) - tx_lvl;
    hp_ok     = tx_free >= TX_LW'(hp_need);
  end

  always_comb begin
    status       = STS_OK;
    rd_vld       = 1'b0;
    rd_byte      = '0;
    ln_vld       = 1'b0;
    ln_byte      = '0;
    halt_nxt     = halt_r;
    thr_nxt      = thr_r;
    pend_vld_nxt = pend_vld_r;
    pend_xon_nxt = pend_xon_r;
    idle_nxt     = idle_r;
    hp_go        = 1'b0;
    rx_req       = '0;
    tx_req       = '0;
    tx_req.wdata2 = CH_LF;

    unique case (op_r)
      OP_WRITE: begin
        if (hp_ok) hp_go = 1'b1;
        else status = STS_WR_REFUSED;
      end
      OP_READ: begin
        if (rx_lvl == '0) begin
          status = STS_RD_REFUSED;
        end else begin
          rx_req.pop = 1'b1;
          rd_vld     = 1'b1;
          rd_byte    = rx_q;
          if (xon_fire) begin
            thr_nxt = 1'b0;
            if (idle_r) begin
              ln_vld   = 1'b1;
              ln_byte  = CH_XON;
              idle_nxt = 1'b0;
            end else begin
              pend_vld_nxt = 1'b1;
              pend_xon_nxt = 1'b1;
            end
          end
          if (echo_r && hp_ok) hp_go = 1'b1;
        end
      end
      OP_RECV: begin
        if (honor_r && byte_r == CH_XOFF) begin
          halt_nxt = 1'b1;
          status   = STS_FLOW;
        end else if (halt_r && (byte_r == CH_XON || anyres_r)) begin
          halt_nxt = 1'b0;
          status   = STS_FLOW;
          if (tx_lvl != '0 && idle_r) begin
            tx_req.pop = 1'b1;
            ln_vld     = 1'b1;
            ln_byte    = tx_q;
            idle_nxt   = 1'b0;
          end
        end else if (honor_r && byte_r == CH_XON) begin
          status = STS_FLOW;
        end else if (rx_lvl >= RX_LW'(RX_DEPTH)) begin
          status = STS_RX_DROP;
        end else begin
          rx_req.push  = 1'b1;
          rx_req.wdata = byte_r;
          if (sxoff_r && !thr_r && (rx_lvl + RX_LW'(1)) >= RX_STOP) begin
            thr_nxt = 1'b1;
            if (idle_r) begin
              ln_vld   = 1'b1;
              ln_byte  = CH_XOFF;
              idle_nxt = 1'b0;
            end else begin
              pend_vld_nxt = 1'b1;
              pend_xon_nxt = 1'b0;
            end
          end
        end
      end
      OP_TXRDY: begin
        idle_nxt = 1'b1;
        if (pend_vld_r) begin
          ln_vld       = 1'b1;
          ln_byte      = pend_xon_r ? CH_XON : CH_XOFF;
          idle_nxt     = 1'b0;
          pend_vld_nxt = 1'b0;
          pend_xon_nxt = 1'b0;
        end else if (!halt_r && tx_lvl != '0) begin
          tx_req.pop = 1'b1;
          ln_vld     = 1'b1;
          ln_byte    = tx_q;
          idle_nxt   = 1'b0;
        end
      end
      OP_DRAIN: begin
        if (tx_lvl == '0) begin
          status = STS_RD_REFUSED;
        end else begin
          tx_req.pop = 1'b1;
          rd_vld     = 1'b1;
          rd_byte    = tx_q;
        end
      end
      default: ;
    endcase

    // An LF with CR insertion goes out as CR on the line with LF into the ring, or as CR,LF into the ring
    if (hp_go) begin
      if (hp_direct) begin
        ln_vld       = 1'b1;
        ln_byte      = hp_lf ? CH_CR : hp_byte;
        idle_nxt     = 1'b0;
        tx_req.push  = hp_lf;
        tx_req.wdata = CH_LF;
      end else begin
        tx_req.push  = 1'b1;
        tx_req.push2 = hp_lf;
        tx_req.wdata = hp_lf ? CH_CR : hp_byte;
      end
    end
  end

  assign rx_cmd = commit ? rx_req : '0;
  assign tx_cmd = commit ? tx_req : '0;

  assign out_nxt = {7'b0, thr_nxt, halt_nxt, FILL_W'(tx_lvl_nxt), FILL_W'(rx_lvl_nxt),
                    ln_byte, ln_vld, rd_byte, rd_vld, status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      halt_r     <= 1'b0;
      thr_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      pend_xon_r <= 1'b0;
      idle_r     <= 1'b1;
      out_vld_r  <= 1'b0;
      echo_r     <= 1'b0;
      crlf_r     <= 1'b1;
      honor_r    <= 1'b1;
      sxoff_r    <= 1'b1;
      anyres_r   <= 1'b1;
    end else begin
      st_r <= st_nxt;
      if (commit) begin
        halt_r     <= halt_nxt;
        thr_r      <= thr_nxt;
        pend_vld_r <= pend_vld_nxt;
        pend_xon_r <= pend_xon_nxt;
        idle_r     <= idle_nxt;
        out_vld_r  <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ECHO:       echo_r   <= cfg_data;
          CFG_CRLF:       crlf_r   <= cfg_data;
          CFG_HONOR_XOFF: honor_r  <= cfg_data;
          CFG_SEND_XOFF:  sxoff_r  <= cfg_data;
          CFG_ANY_RESUME: anyres_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_tuser);
      byte_r <= in_tdata;
    end
    if (commit) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

FILE: design/uartrb_chk.sv
module uartrb_chk
  import uartrb_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // One item in flight: after a beat is taken, the input side closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in flight");

  a_rd_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[3]) |-> (out_tdata[11:4] == '0))
    else $error("read byte set without read valid");

  a_refused_no_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] == STS_WR_REFUSED) |-> (!out_tdata[12] && !out_tdata[3]))
    else $error("refused write still moved data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output beat changed");

endmodule

bind uart_ring_buffers_xon_xoff uartrb_chk u_chk (.*);

FILE: tb/sv/uart_ring_buffers_xon_xoff_tb.sv
`timescale 1ns / 100ps

module uart_ring_buffers_xon_xoff_tb;
  import uartrb_pkg::*;

  localparam int RXD      = DEF_RX_DEPTH;
  localparam int TXD      = DEF_TX_DEPTH;
  localparam int RX_STOP  = RXD * 3 / 4;
  localparam int RX_START = RXD / 2;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
  } host_line_op_t;

  typedef struct packed {
    logic [OUT_DATA_W-42:0] pad;
    logic                   throttled;
    logic                   halted;
    logic [FILL_W-1:0]      tx_fill;
    logic [FILL_W-1:0]      rx_fill;
    logic [BYTE_W-1:0]      line_byte;
    logic                   line_valid;
    logic [BYTE_W-1:0]      read_byte;
    logic                   read_valid;
    status_t                status;
  } engine_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;   // [7:0] data_byte
  logic [OP_W-1:0]       in_tuser;   // [2:0] operation
  logic                  out_tvalid;
  logic                  out_tready;
  // [2:0] status, [3] read_valid, [11:4] read_byte, [12] line_tx_valid,
  // [20:13] line_tx_byte, [29:21] rx_fill, [38:30] tx_fill, [39] tx_halted,
  // [40] rx_throttled, [47:41] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic                  cfg_data;

  uart_ring_buffers_xon_xoff #(
    .RX_DEPTH(RXD),
    .TX_DEPTH(TXD)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the buffer engine
  logic [BYTE_W-1:0] rx_ring [RXD];
  logic [BYTE_W-1:0] tx_ring [TXD];
  int                rx_rd, rx_wr, rx_cnt;
  int                tx_rd, tx_wr, tx_cnt;
  logic [BYTE_W-1:0] flow_hold;
  bit                xoff_sent, partner_halt, line_free;
  bit                echo_on, crlf_on, honor_on, sendflow_on, anyresume_on;
  bit                line_v;
  logic [BYTE_W-1:0] line_b;

  host_line_op_t     host_line_ops[$];
  engine_report_t    engine_reports_due[$];
  host_line_op_t     drv_op;
  bit                beat_sent;
  bit                no_gaps;
  int                mismatches;

  function automatic bit offer_line(logic [BYTE_W-1:0] c);
    if (!line_free) return 1'b0;
    line_free = 1'b0;
    line_v    = 1'b1;
    line_b    = c;
    return 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] tx_take();
    logic [BYTE_W-1:0] c;
    c      = tx_ring[tx_rd];
    tx_rd  = (tx_rd + 1) % TXD;
    tx_cnt = tx_cnt - 1;
    return c;
  endfunction

  function automatic void tx_push_or_send(logic [BYTE_W-1:0] c);
    if (tx_cnt == 0 && !partner_halt && offer_line(c)) return;
    tx_ring[tx_wr] = c;
    tx_wr  = (tx_wr + 1) % TXD;
    tx_cnt = tx_cnt + 1;
  endfunction

  function automatic bit host_write(logic [BYTE_W-1:0] c);
    bit lf;
    bit direct;
    int need;
    lf     = (c == CH_LF) && crlf_on;
    direct = tx_cnt == 0 && !partner_halt && line_free;
    need   = (lf ? 2 : 1) - (direct ? 1 : 0);
    if (TXD - tx_cnt < need) return 1'b0;
    if (lf) tx_push_or_send(CH_CR);
    tx_push_or_send(c);
    return 1'b1;
  endfunction

  // A newer flow byte replaces one that is still waiting for the line
  function automatic void flow_emit(logic [BYTE_W-1:0] c);
    if (!offer_line(c)) flow_hold = c;
  endfunction

  function automatic engine_report_t engine_step(logic [OP_W-1:0] op,
                                                 logic [BYTE_W-1:0] c);
    engine_report_t r;
    status_t        st;
    bit             rv;
    logic [BYTE_W-1:0] rb;
    st     = STS_OK;
    rv     = 1'b0;
    rb     = '0;
    line_v = 1'b0;
    line_b = '0;
    case (op)
      OP_WRITE: begin
        if (!host_write(c)) st = STS_WR_REFUSED;
      end
      OP_READ: begin
        if (rx_cnt == 0) begin
          st = STS_RD_REFUSED;
        end else begin
          rb     = rx_ring[rx_rd];
          rx_rd  = (rx_rd + 1) % RXD;
          rx_cnt = rx_cnt - 1;
          rv     = 1'b1;
          if (xoff_sent && rx_cnt <= RX_START) begin
            flow_emit(CH_XON);
            xoff_sent = 1'b0;
          end
          if (echo_on) void'(host_write(rb));
        end
      end
      OP_RECV: begin
        if (honor_on && c == CH_XOFF) begin
          partner_halt = 1'b1;
          st = STS_FLOW;
        end else if (partner_halt && (c == CH_XON || anyresume_on)) begin
          partner_halt = 1'b0;
          st = STS_FLOW;
          if (tx_cnt > 0 && line_free) void'(offer_line(tx_take()));
        end else if (honor_on && c == CH_XON) begin
          st = STS_FLOW;
        end else if (rx_cnt >= RXD) begin
          st = STS_RX_DROP;
        end else begin
          rx_ring[rx_wr] = c;
          rx_wr  = (rx_wr + 1) % RXD;
          rx_cnt = rx_cnt + 1;
          if (sendflow_on && !xoff_sent && rx_cnt >= RX_STOP) begin
            flow_emit(CH_XOFF);
            xoff_sent = 1'b1;
          end
        end
      end
      OP_TXRDY: begin
        line_free = 1'b1;
        if (flow_hold != '0) begin
          void'(offer_line(flow_hold));
          flow_hold = '0;
        end else if (!partner_halt && tx_cnt > 0) begin
          void'(offer_line(tx_take()));
        end
      end
      OP_DRAIN: begin
        if (tx_cnt == 0) begin
          st = STS_RD_REFUSED;
        end else begin
          rb = tx_take();
          rv = 1'b1;
        end
      end
      default: ;
    endcase
    r.pad        = '0;
    r.throttled  = xoff_sent;
    r.halted     = partner_halt;
    r.tx_fill    = FILL_W'(tx_cnt);
    r.rx_fill    = FILL_W'(rx_cnt);
    r.line_byte  = line_v ? line_b : '0;
    r.line_valid = line_v;
    r.read_byte  = rv ? rb : '0;
    r.read_valid = rv;
    r.status     = st;
    return r;
  endfunction

  function automatic void queue_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] d);
    host_line_op_t t;
    t.op   = op;
    t.data = d;
    host_line_ops.push_back(t);
  endfunction

  // Random mix of all operations, weighted toward traffic that moves the rings
  function automatic void queue_mixed(int n);
    int pick;
    logic [BYTE_W-1:0] d;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      d    = 8'($urandom_range(0, 255));
      if (pick < 30) begin
        queue_op(OP_WRITE, ($urandom_range(0, 6) == 0) ? CH_LF : d);
      end else if (pick < 50) begin
        queue_op(OP_READ, d);
      end else if (pick < 75) begin
        case ($urandom_range(0, 9))
          0:       queue_op(OP_RECV, CH_XOFF);
          1:       queue_op(OP_RECV, CH_XON);
          default: queue_op(OP_RECV, d);
        endcase
      end else if (pick < 90) begin
        queue_op(OP_TXRDY, d);
      end else if (pick < 96) begin
        queue_op(OP_DRAIN, d);
      end else begin
        queue_op(OP_W'($urandom_range(OP_DRAIN + 1, 2**OP_W - 1)), d);
      end
    end
  endfunction

  task automatic cfg_write(cfg_idx_t idx, bit val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ECHO:       echo_on      = val;
      CFG_CRLF:       crlf_on      = val;
      CFG_HONOR_XOFF: honor_on     = val;
      CFG_SEND_XOFF:  sendflow_on  = val;
      CFG_ANY_RESUME: anyresume_on = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(bit echo, bit crlf, bit honor, bit sendflow, bit anyres);
    cfg_write(CFG_ECHO, echo);
    cfg_write(CFG_CRLF, crlf);
    cfg_write(CFG_HONOR_XOFF, honor);
    cfg_write(CFG_SEND_XOFF, sendflow);
    cfg_write(CFG_ANY_RESUME, anyres);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (host_line_ops.size() != 0 || in_tvalid || engine_reports_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input side: hold a beat until taken, then load the next one or idle
  always @(negedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= 13);
    if (!in_tvalid || beat_sent) begin
      beat_sent = 1'b0;
      if (host_line_ops.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 13)) begin
        drv_op = host_line_ops.pop_front();
        in_tuser  <= drv_op.op;
        in_tdata  <= drv_op.data;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      engine_reports_due.push_back(engine_step(in_tuser, in_tdata));
      beat_sent = 1'b1;
    end
  end

  always @(posedge clk) begin
    engine_report_t got;
    engine_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = engine_report_t'(out_tdata);
      if (engine_reports_due.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat %h at %0t", out_tdata, $time);
      end else begin
        want = engine_reports_due.pop_front();
        if (got.status !== want.status || got.read_valid !== want.read_valid ||
            got.read_byte !== want.read_byte || got.line_valid !== want.line_valid ||
            got.line_byte !== want.line_byte || got.rx_fill !== want.rx_fill ||
            got.tx_fill !== want.tx_fill || got.halted !== want.halted ||
            got.throttled !== want.throttled || got.pad !== want.pad) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: status/rv/rb/lv/lb/rx/tx/halt/thr/pad", $time);
            $display("  expected %0d %b %h %b %h %0d %0d %b %b %h", want.status,
                     want.read_valid, want.read_byte, want.line_valid, want.line_byte,
                     want.rx_fill, want.tx_fill, want.halted, want.throttled, want.pad);
            $display("  actual   %0d %b %h %b %h %0d %0d %b %b %h", got.status,
                     got.read_valid, got.read_byte, got.line_valid, got.line_byte,
                     got.rx_fill, got.tx_fill, got.halted, got.throttled, got.pad);
          end
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("uart_ring_buffers_xon_xoff verification failed");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = 1'b0;
    no_gaps    = 1'b0;
    mismatches = 0;
    beat_sent  = 1'b0;
    rx_rd = 0; rx_wr = 0; rx_cnt = 0;
    tx_rd = 0; tx_wr = 0; tx_cnt = 0;
    flow_hold    = '0;
    xoff_sent    = 1'b0;
    partner_halt = 1'b0;
    line_free    = 1'b1;
    echo_on      = 1'b0;
    crlf_on      = 1'b1;
    honor_on     = 1'b1;
    sendflow_on  = 1'b1;
    anyresume_on = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: line idle vs busy, CR insertion, halt and resume, stray XON,
    // empty read and drain, unused operation codes
    queue_op(OP_WRITE, 8'h00);
    queue_op(OP_WRITE, 8'hFF);
    queue_op(OP_WRITE, CH_LF);
    queue_op(OP_TXRDY, 8'h00);
    queue_op(OP_RECV, CH_XOFF);
    queue_op(OP_TXRDY, 8'hFF);
    queue_op(OP_RECV, 8'h55);
    queue_op(OP_RECV, CH_XON);
    queue_op(OP_RECV, 8'h00);
    queue_op(OP_RECV, 8'hFF);
    queue_op(OP_RECV, CH_LF);
    queue_op(OP_READ, 8'h00);
    queue_op(OP_READ, 8'hFF);
    queue_op(OP_DRAIN, 8'h00);
    queue_op(OP_DRAIN, 8'h00);
    queue_op(OP_DRAIN, 8'h00);
    queue_op(OP_READ, 8'h00);
    queue_op(OP_READ, 8'h00);
    for (int k = OP_DRAIN + 1; k < 2**OP_W; k++) queue_op(OP_W'(k), 8'hAA);
    queue_op(OP_TXRDY, 8'h00);
    queue_op(OP_TXRDY, 8'h00);
    queue_mixed(20);
    wait_drained();

    // Fill both rings to the brim with no gaps on either side: refused writes,
    // XOFF held while the line is busy, drops, echo with no room, XON replacing
    // the held XOFF
    apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    no_gaps = 1'b1;
    queue_op(OP_WRITE, 8'h41);
    repeat (130) queue_op(OP_WRITE, CH_LF);
    queue_op(OP_DRAIN, 8'($urandom_range(0, 255)));
    queue_op(OP_WRITE, CH_LF);
    queue_op(OP_WRITE, 8'h42);
    repeat (262) queue_op(OP_RECV, 8'($urandom_range(0, 255)));
    repeat (136) queue_op(OP_READ, 8'($urandom_range(0, 255)));
    repeat (10) begin
      queue_op(OP_TXRDY, 8'($urandom_range(0, 255)));
      queue_op(OP_DRAIN, 8'($urandom_range(0, 255)));
    end
    wait_drained();
    no_gaps = 1'b0;

    apply_settings(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_mixed(20);
    wait_drained();

    apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_mixed(20);
    wait_drained();

    if (mismatches == 0 && engine_reports_due.size() == 0)
      $display("uart_ring_buffers_xon_xoff verification clean");
    else
      $display("uart_ring_buffers_xon_xoff verification failed");
    $finish;
  end

endmodule
